// ===== src/mstw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstw_pkg: shared definitions of the multi-slot task watchdog
// Sizes, operation and event codes, register indexes, transaction payload
// structs and the sequencer state type.
// ----------------------------------------------------------------------------
package mstw_pkg;

    localparam int SLOTS       = 16;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BUF_W       = $clog2(MAX_RESULTS);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Input kinds.
    localparam logic [2:0] KIND_TICK       = 3'd0;
    localparam logic [2:0] KIND_TASK_START = 3'd1;
    localparam logic [2:0] KIND_TASK_END   = 3'd2;
    localparam logic [2:0] KIND_EXEC_START = 3'd3;
    localparam logic [2:0] KIND_ARM        = 3'd4;
    localparam logic [2:0] KIND_DISARM     = 3'd5;

    // Event codes.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_WARNING   = 3'd1;
    localparam logic [2:0] EV_TASK_TO   = 3'd2;
    localparam logic [2:0] EV_GLOBAL_TO = 3'd3;
    localparam logic [2:0] EV_EXEC_DEAD = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CHK_PERIOD     = 3'd0;
    localparam logic [2:0] CFG_GLOBAL_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_DEFAULT_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_WARN_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_EXEC_PRESENT   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] task_limit;
        logic        executor_ready;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  event_slot;
        logic [31:0] elapsed;
        logic [4:0]  active_count;
        logic        halted;
        logic        last;
    } t_out;

    // One buffered event of a check.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  event_slot;
        logic [31:0] elapsed;
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GLOBAL,
        S_SCAN,
        S_EXEC,
        S_LOAD,
        S_PUT
    } t_state;

endpackage
`default_nettype wire

// ===== src/multi_slot_task_watchdog_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_task_watchdog_top: watchdog over a table of task slots
// Tracks task slots against a free-running tick count and reports warnings,
// task timeouts, a global timeout and an unresponsive executor.
// ----------------------------------------------------------------------------
// The block takes one input transaction at a time and is not ready while it
// works on it. Any kind other than a check tick goes from the accept cycle
// to loading the single result into the output register, and waits while
// that register holds a result not yet taken. A tick that triggers a check
// runs the global check, the slot scan over all 16 slots and the executor
// check, then loads and puts each of its N results in turn to drain the
// event buffer. A timeout ends the scan early. The pace is set by the single
// shared subtract-and-compare unit, which sees one slot per cycle through the
// registered read port of the slot tables, and by the one-read event buffer.
// The output register holds a finished result while the next input
// transaction is already accepted.

module multi_slot_task_watchdog_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire mstw_pkg::t_in        i_in_data,
    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output mstw_pkg::t_out            o_out_data
);

    localparam int TB = mstw_pkg::TIME_BITS;
    localparam int SW = mstw_pkg::SLOT_W;

    // Sequencer state.
    mstw_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [15:0]   r_chk_period;
    logic [31:0]   r_global_limit;
    logic [31:0]   r_default_limit;
    logic [31:0]   r_warn_limit;
    logic          r_exec_present;

    // Watchdog state.
    logic [TB-1:0] r_now;
    logic [TB-1:0] r_exec_start;
    logic [15:0]   r_icount;
    logic          r_armed;
    logic          r_tripped;
    logic [mstw_pkg::SLOTS-1:0] r_slot_valid;
    logic [mstw_pkg::SLOTS-1:0] r_slot_warned;
    logic [4:0]    r_active;

    // Slot tables, read one entry per cycle during the scan.
    logic [TB-1:0] mem_start [mstw_pkg::SLOTS];
    logic [31:0]   mem_limit [mstw_pkg::SLOTS];
    logic [TB-1:0] r_sstart;
    logic [31:0]   r_slimit;
    logic [SW-1:0] rd_addr;

    // Scan and result bookkeeping.
    logic [SW-1:0] r_idx;
    logic          r_ready_bit;
    logic [mstw_pkg::RCNT_W-1:0] r_n;
    logic [mstw_pkg::BUF_W-1:0]  r_rd;
    mstw_pkg::t_event evbuf [mstw_pkg::MAX_RESULTS];
    mstw_pkg::t_event r_bdata;

    // Output register.
    logic           r_out_valid;
    mstw_pkg::t_out r_out;

    // Shared subtract-and-compare unit and control.
    logic [TB-1:0] sub_b;
    logic [TB-1:0] el;
    logic [31:0]   lim;
    logic          lim_hit;
    logic          warn_hit;
    logic          cur_valid;
    logic          scan_last;
    logic          accept;
    logic          out_free;
    logic [15:0]   ic_inc;
    logic [15:0]   period;
    logic          check_due;
    logic          put_last;
    logic          slot_ok;
    logic [SW-1:0] in_slot;

    logic             push;
    mstw_pkg::t_event push_ev;
    logic             set_trip;
    logic             set_warn;
    logic             load_out;

    assign o_in_ready  = (r_state == mstw_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The global check measures from the execution start; the slot scan
    // measures from the start time of the slot under test. Time wraps.
    assign sub_b     = (r_state == mstw_pkg::S_GLOBAL) ? r_exec_start : r_sstart;
    assign el        = r_now - sub_b;
    assign lim       = (r_state == mstw_pkg::S_GLOBAL) ? r_global_limit : r_slimit;
    assign lim_hit   = (lim != 32'd0) && (el > TB'(lim));
    // A warning fires once per task and only while the event budget leaves
    // room for a later timeout or executor event.
    assign warn_hit  = (r_warn_limit != 32'd0) && !r_slot_warned[r_idx] &&
                       (el > TB'(r_warn_limit)) &&
                       (r_n < mstw_pkg::RCNT_W'(mstw_pkg::MAX_RESULTS - 1));
    assign cur_valid = r_slot_valid[r_idx];
    assign scan_last = (r_idx == SW'(mstw_pkg::SLOTS - 1));

    // A check interval of zero behaves as one.
    assign ic_inc    = r_icount + 16'd1;
    assign period    = (r_chk_period == 16'd0) ? 16'd1 : r_chk_period;
    assign check_due = (i_in_data.kind == mstw_pkg::KIND_TICK) && r_armed &&
                       !r_tripped && (ic_inc >= period);

    assign put_last  = (r_n == '0) ||
                       ({1'b0, r_rd} == (r_n - mstw_pkg::RCNT_W'(1)));

    assign slot_ok   = (32'(i_in_data.slot) < 32'(mstw_pkg::SLOTS));
    assign in_slot   = SW'(i_in_data.slot);

    assign rd_addr   = (r_state == mstw_pkg::S_SCAN) ? (r_idx + SW'(1)) : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mstw_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = check_due ? mstw_pkg::S_GLOBAL : mstw_pkg::S_PUT;
                end
            end
            mstw_pkg::S_GLOBAL: begin
                n_state = lim_hit ? mstw_pkg::S_LOAD : mstw_pkg::S_SCAN;
            end
            mstw_pkg::S_SCAN: begin
                if (cur_valid && lim_hit) begin
                    n_state = mstw_pkg::S_LOAD;
                end else if (scan_last) begin
                    n_state = mstw_pkg::S_EXEC;
                end
            end
            mstw_pkg::S_EXEC: begin
                n_state = mstw_pkg::S_LOAD;
            end
            mstw_pkg::S_LOAD: begin
                n_state = mstw_pkg::S_PUT;
            end
            mstw_pkg::S_PUT: begin
                if (out_free) begin
                    n_state = put_last ? mstw_pkg::S_IDLE : mstw_pkg::S_LOAD;
                end
            end
            default: n_state = mstw_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        push     = 1'b0;
        push_ev  = '0;
        set_trip = 1'b0;
        set_warn = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            mstw_pkg::S_IDLE: begin
            end
            mstw_pkg::S_GLOBAL: begin
                if (lim_hit) begin
                    push     = 1'b1;
                    push_ev  = '{mstw_pkg::EV_GLOBAL_TO, 4'd0, 32'(el)};
                    set_trip = 1'b1;
                end
            end
            mstw_pkg::S_SCAN: begin
                if (cur_valid) begin
                    if (lim_hit) begin
                        push     = 1'b1;
                        push_ev  = '{mstw_pkg::EV_TASK_TO, 4'(r_idx), 32'(el)};
                        set_trip = 1'b1;
                    end else if (warn_hit) begin
                        push     = 1'b1;
                        push_ev  = '{mstw_pkg::EV_WARNING, 4'(r_idx), 32'(el)};
                        set_warn = 1'b1;
                    end
                end
            end
            mstw_pkg::S_EXEC: begin
                if (r_exec_present && !r_ready_bit) begin
                    push     = 1'b1;
                    push_ev  = '{mstw_pkg::EV_EXEC_DEAD, 4'd0, 32'd0};
                    set_trip = 1'b1;
                end
            end
            mstw_pkg::S_LOAD: begin
            end
            mstw_pkg::S_PUT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= mstw_pkg::S_IDLE;
            r_chk_period     <= 16'd1;
            r_global_limit   <= '0;
            r_default_limit  <= '0;
            r_warn_limit     <= '0;
            r_exec_present   <= 1'b0;
            r_now            <= '0;
            r_exec_start     <= '0;
            r_icount         <= '0;
            r_armed          <= 1'b0;
            r_tripped        <= 1'b0;
            r_slot_valid     <= '0;
            r_active         <= '0;
            r_idx            <= '0;
            r_n              <= '0;
            r_rd             <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mstw_pkg::CFG_CHK_PERIOD:     r_chk_period     <= i_cfg_data[15:0];
                    mstw_pkg::CFG_GLOBAL_LIMIT:   r_global_limit   <= i_cfg_data;
                    mstw_pkg::CFG_DEFAULT_LIMIT:  r_default_limit  <= i_cfg_data;
                    mstw_pkg::CFG_WARN_LIMIT:     r_warn_limit     <= i_cfg_data;
                    mstw_pkg::CFG_EXEC_PRESENT:   r_exec_present   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                r_idx <= '0;
                r_n   <= '0;
                r_rd  <= '0;
                case (i_in_data.kind)
                    mstw_pkg::KIND_TICK: begin
                        r_now <= r_now + TB'(1);
                        if (r_armed && !r_tripped) begin
                            r_icount <= check_due ? 16'd0 : ic_inc;
                        end
                    end
                    mstw_pkg::KIND_TASK_START: begin
                        if (slot_ok) begin
                            r_slot_valid[in_slot] <= 1'b1;
                            if (!r_slot_valid[in_slot]) begin
                                r_active <= r_active + 5'd1;
                            end
                        end
                    end
                    mstw_pkg::KIND_TASK_END: begin
                        if (slot_ok && r_slot_valid[in_slot]) begin
                            r_slot_valid[in_slot] <= 1'b0;
                            r_active              <= r_active - 5'd1;
                        end
                    end
                    mstw_pkg::KIND_EXEC_START: begin
                        r_exec_start <= r_now;
                    end
                    mstw_pkg::KIND_ARM: begin
                        if (!r_armed) begin
                            r_armed   <= 1'b1;
                            r_tripped <= 1'b0;
                            r_icount  <= '0;
                        end
                    end
                    mstw_pkg::KIND_DISARM: begin
                        r_armed <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == mstw_pkg::S_SCAN) begin
                r_idx <= r_idx + SW'(1);
            end
            if (push) begin
                r_n <= r_n + mstw_pkg::RCNT_W'(1);
            end
            if (set_trip) begin
                r_tripped <= 1'b1;
            end
            if (load_out && !put_last) begin
                r_rd <= r_rd + mstw_pkg::BUF_W'(1);
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, slot tables and the event buffer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ready_bit <= i_in_data.executor_ready;
            if (i_in_data.kind == mstw_pkg::KIND_TASK_START && slot_ok) begin
                mem_start[in_slot]     <= r_now;
                mem_limit[in_slot]     <= (i_in_data.task_limit != 32'd0) ?
                                          i_in_data.task_limit : r_default_limit;
                r_slot_warned[in_slot] <= 1'b0;
            end
        end
        if (set_warn) begin
            r_slot_warned[r_idx] <= 1'b1;
        end
        r_sstart <= mem_start[rd_addr];
        r_slimit <= mem_limit[rd_addr];

        if (push) begin
            evbuf[r_n[mstw_pkg::BUF_W-1:0]] <= push_ev;
        end
        r_bdata <= evbuf[r_rd];

        if (load_out) begin
            if (r_n == '0) begin
                r_out.event_res  <= mstw_pkg::EV_NONE;
                r_out.event_slot <= 4'd0;
                r_out.elapsed    <= 32'd0;
            end else begin
                r_out.event_res  <= r_bdata.event_res;
                r_out.event_slot <= r_bdata.event_slot;
                r_out.elapsed    <= r_bdata.elapsed;
            end
            r_out.active_count <= r_active;
            r_out.halted       <= !r_armed || r_tripped;
            r_out.last         <= put_last;
        end
    end

    // The block is busy in the cycle after it takes an input transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input accepted on two consecutive cycles");

    // A check never buffers more events than the result budget allows.
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= mstw_pkg::RCNT_W'(mstw_pkg::MAX_RESULTS))
        else $error("event buffer overflow");

    // Any timeout leaves the watchdog halted.
    a_timeout_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.event_res == mstw_pkg::EV_TASK_TO ||
                         o_out_data.event_res == mstw_pkg::EV_GLOBAL_TO ||
                         o_out_data.event_res == mstw_pkg::EV_EXEC_DEAD))
        |-> o_out_data.halted)
        else $error("timeout reported without halt");

    // An empty result is always the only one of its input.
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_res == mstw_pkg::EV_NONE)
        |-> o_out_data.last)
        else $error("empty result not marked last");

    // The occupancy count never exceeds the number of slots.
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_active) <= 32'(mstw_pkg::SLOTS))
        else $error("active slot count out of range");

endmodule
`default_nettype wire
